/* rtl/core/xcfp_pkg.sv */
package xcfp_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned AddrWidth   = 3;
   localparam int unsigned DataWidth   = 32;

   localparam logic [ByteWidth-1:0] MarkerReset = 8'h55;

   // register indexes on the csr port
   localparam logic [0:0] RegStartMarker = 1'b0;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      PH_WAIT  = 5'b00001,
      PH_ID    = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   typedef struct packed {
      status_type status;
      byte_type   frame_id;
      byte_type   frame_length;
      byte_type   payload_byte;
      logic       payload_strobe;
   } result_type;

endpackage

/* rtl/core/xor_checksum_frame_parser.sv */
// Byte-stream deframer: hunts for the start marker (csr register 0, reset 0x55), then
// takes an id byte, a length byte, that many payload bytes and a checksum byte, which
// must equal the XOR of id, length and payload. Every accepted byte yields one result
// transfer: status 0 while a frame is in progress or no frame is open, 1 for a good
// checksum, 2 for a mismatch; payload bytes are passed through with payload_strobe set.
// One byte is taken every cycle while req_ready is high; its result is registered in a two-entry
// output buffer, and req_ready drops only when that buffer is full. The marker is not
// looked for inside a frame. Write the marker only while the stream is idle.
module xor_checksum_frame_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_frame_id,
   output logic [7:0]                     rsp_frame_length,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_payload_strobe,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xcfp_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [xcfp_pkg::DataWidth-1:0] csr_pwdata,
   output logic [xcfp_pkg::DataWidth-1:0] csr_prdata,
   output logic                           csr_pready
);
   import xcfp_pkg::*;

   byte_type   start_marker;
   result_type next_result;
   result_type out_data;
   logic       take;
   logic       space;

   assign take      = req_valid && space;
   assign req_ready = space;

   xcfp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .start_marker (start_marker)
   );

   xcfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .rx_byte      (req_rx_byte),
      .start_marker (start_marker),
      .result       (next_result)
   );

   xcfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (next_result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_status         = out_data.status;
   assign rsp_frame_id       = out_data.frame_id;
   assign rsp_frame_length   = out_data.frame_length;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_payload_strobe = out_data.payload_strobe;

endmodule

/* rtl/core/xcfp_csr.sv */
module xcfp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xcfp_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [xcfp_pkg::DataWidth-1:0] csr_pwdata,
   output logic [xcfp_pkg::DataWidth-1:0] csr_prdata,
   output logic                           csr_pready,
   output xcfp_pkg::byte_type             start_marker
);
   import xcfp_pkg::*;

   byte_type   marker_ff;
   logic [0:0] reg_index;
   logic       wr_en;

   assign reg_index = csr_paddr[2:2];
   assign wr_en     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MarkerReset;
      end else if (wr_en && (reg_index == RegStartMarker)) begin
         marker_ff <= csr_pwdata[ByteWidth-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == RegStartMarker) begin
         csr_prdata = {{(DataWidth-ByteWidth){1'b0}}, marker_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign start_marker = marker_ff;

endmodule

/* rtl/core/xcfp_parser.sv */
module xcfp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  xcfp_pkg::byte_type     rx_byte,
   input  xcfp_pkg::byte_type     start_marker,
   output xcfp_pkg::result_type   result
);
   import xcfp_pkg::*;

   phase_type phase_ff, phase_in;
   byte_type  count_ff, count_in;
   byte_type  length_ff, length_in;
   byte_type  id_ff, id_in;
   byte_type  xor_ff, xor_in;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      id_in     = id_ff;
      xor_in    = xor_ff;
      result    = '{status: STATUS_NONE, frame_id: '0, frame_length: '0,
                    payload_byte: '0, payload_strobe: 1'b0};
      case (phase_ff)
         PH_ID: begin
            id_in    = rx_byte;
            xor_in   = rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            xor_in    = xor_ff ^ rx_byte;
            count_in  = '0;
            // empty frame goes straight to the checksum
            phase_in  = (rx_byte == '0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            xor_in                = xor_ff ^ rx_byte;
            count_in              = count_ff + 1'b1;
            result.payload_strobe = 1'b1;
            result.payload_byte   = rx_byte;
            if (count_in >= length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            result.status = (xor_ff == rx_byte) ? STATUS_VALID : STATUS_MISMATCH;
            phase_in      = PH_WAIT;
         end
         default: begin
            if (rx_byte == start_marker) begin
               xor_in   = '0;
               count_in = '0;
               phase_in = PH_ID;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      endcase
      result.frame_id     = id_in;
      result.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         count_ff  <= '0;
         length_ff <= '0;
         id_ff     <= '0;
         xor_ff    <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         xor_ff    <= xor_in;
      end
   end

endmodule

/* rtl/core/xcfp_out_buf.sv */
module xcfp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  xcfp_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output xcfp_pkg::result_type out_data
);
   import xcfp_pkg::*;

   result_type main_ff, skid_ff;
   logic       main_valid_ff, skid_valid_ff;
   logic       pop;

   assign pop = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff <= push_data;
         end else begin
            skid_ff <= push_data;
         end
      end
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

/* rtl/core/xcfp_checker.sv */
module xcfp_assertions (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_frame_id,
   input logic [7:0] rsp_frame_length,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_payload_strobe
);
   import xcfp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_id) && $stable(rsp_frame_length)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_strobe))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_NONE) || (rsp_status == STATUS_VALID)
         || (rsp_status == STATUS_MISMATCH))
      else $error("status code out of range");

   // a checksum byte is never a payload byte
   a_status_no_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_NONE) |-> !rsp_payload_strobe)
      else $error("frame end flagged as payload");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_strobe |-> rsp_payload_byte == '0)
      else $error("payload byte without strobe");

endmodule

bind xor_checksum_frame_parser xcfp_assertions u_xcfp_assertions (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_frame_id       (rsp_frame_id),
   .rsp_frame_length   (rsp_frame_length),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_strobe (rsp_payload_strobe)
);

/* tb/xcfp_checker.sv */
module xcfp_checker
   import xcfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           rsp_status,
   input  logic [7:0]           rsp_frame_id,
   input  logic [7:0]           rsp_frame_length,
   input  logic [7:0]           rsp_payload_byte,
   input  logic                 rsp_payload_strobe,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   input  logic [DataWidth-1:0] csr_prdata,
   input  logic                 csr_pready,
   output int                   mismatches,
   output int                   bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   byte_type   marker_q;
   byte_type   count_q;
   byte_type   length_q;
   byte_type   id_q;
   byte_type   xor_q;
   phase_type  phase_q;
   result_type parsed_q[$];

   function automatic result_type deframe_byte(input byte_type b);
      result_type r;
      r = '0;
      case (phase_q)
         PH_ID: begin
            id_q    = b;
            xor_q   = b;
            phase_q = PH_LEN;
         end
         PH_LEN: begin
            length_q = b;
            xor_q    = xor_q ^ b;
            count_q  = '0;
            phase_q  = (b == 8'd0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            xor_q            = xor_q ^ b;
            r.payload_strobe = 1'b1;
            r.payload_byte   = b;
            count_q          = count_q + 8'd1;
            if (count_q >= length_q) phase_q = PH_CHECK;
         end
         PH_CHECK: begin
            r.status = (xor_q == b) ? STATUS_VALID : STATUS_MISMATCH;
            phase_q  = PH_WAIT;
         end
         default: begin
            // hunting: only the marker opens a frame
            if (b == marker_q) begin
               xor_q   = '0;
               count_q = '0;
               phase_q = PH_ID;
            end else begin
               phase_q = PH_WAIT;
            end
         end
      endcase
      r.frame_id     = id_q;
      r.frame_length = length_q;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type due;
      if (reset) begin
         marker_q   = MarkerReset;
         count_q    = '0;
         length_q   = '0;
         id_q       = '0;
         xor_q      = '0;
         phase_q    = PH_WAIT;
         mismatches = 0;
         parsed_q.delete();
      end else begin
         // result first: it always belongs to a byte taken at an earlier edge
         if (rsp_valid && rsp_ready) begin
            if (parsed_q.size() == 0) begin
               $error("result transfer with no byte outstanding");
               mismatches++;
            end else begin
               due = parsed_q.pop_front();
               if (rsp_status != due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_frame_id != due.frame_id) begin
                  $error("frame_id: expected %0d, actual %0d", due.frame_id, rsp_frame_id);
                  mismatches++;
               end
               if (rsp_frame_length != due.frame_length) begin
                  $error("frame_length: expected %0d, actual %0d",
                         due.frame_length, rsp_frame_length);
                  mismatches++;
               end
               if (rsp_payload_byte != due.payload_byte) begin
                  $error("payload_byte: expected %0d, actual %0d",
                         due.payload_byte, rsp_payload_byte);
                  mismatches++;
               end
               if (rsp_payload_strobe != due.payload_strobe) begin
                  $error("payload_strobe: expected %0d, actual %0d",
                         due.payload_strobe, rsp_payload_strobe);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) parsed_q.push_back(deframe_byte(req_rx_byte));
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[AddrWidth-1:2] == RegStartMarker) begin
            if (csr_pwrite) begin
               marker_q = csr_pwdata[ByteWidth-1:0];
            end else if (csr_prdata != DataWidth'(marker_q)) begin
               $error("start_marker: expected %0d, actual %0d", marker_q, csr_prdata);
               mismatches++;
            end
         end
      end
      bytes_outstanding = parsed_q.size();
   end

endmodule

/* tb/tb.sv */
module tb;
   import xcfp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit     = 3000;
   localparam int ItemsPerPhase = 150;
   localparam int DrainCycles   = 8;
   localparam int HoldCycles    = 300;

   localparam logic [AddrWidth-1:0] MarkerAddr = {RegStartMarker, 2'b00};
   // one index past the last register
   localparam logic [AddrWidth-1:0] SpareAddr  = 3'b100;

   logic                 clock              = 1'b0;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte        = '0;
   logic                 rsp_valid;
   logic                 rsp_ready          = 1'b0;
   logic [1:0]           rsp_status;
   logic [7:0]           rsp_frame_id;
   logic [7:0]           rsp_frame_length;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_payload_strobe;
   logic                 csr_psel           = 1'b0;
   logic                 csr_penable        = 1'b0;
   logic                 csr_pwrite         = 1'b0;
   logic [AddrWidth-1:0] csr_paddr          = '0;
   logic [DataWidth-1:0] csr_pwdata         = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   int       mismatches;
   int       bytes_outstanding;
   int       sender_idle_pct    = 0;
   int       receiver_stall_pct = 0;
   int       hold_cycles        = 0;
   int       frame_bytes;
   byte_type marker             = MarkerReset;

   xor_checksum_frame_parser u_top (.*);

   xcfp_checker u_checker (.*);

   initial forever #2 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when one is requested
   initial forever begin
      @(posedge clock);
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_byte(input byte_type b);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (bytes_outstanding != 0);
      @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [AddrWidth-1:0] addr,
                             input logic [DataWidth-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // fixed_len < 0 picks a length at random, mostly short
   task automatic send_random_frame(input int fixed_len);
      byte_type id;
      byte_type len;
      byte_type sum;
      byte_type b;
      int       noise;
      int       stop_at;
      noise = $urandom_range(0, 2);
      repeat (noise) begin
         b = byte_type'($urandom);
         if (b == marker) b = b ^ 8'h01;
         send_byte(b);
      end
      id = byte_type'($urandom);
      if (fixed_len >= 0) len = byte_type'(fixed_len);
      else if ($urandom_range(99) == 0) len = byte_type'($urandom_range(128, 255));
      else len = byte_type'($urandom_range(0, 8));
      // a few frames are cut short, so the next frame lands inside this one
      if (fixed_len < 0 && $urandom_range(9) == 0) stop_at = $urandom_range(1, len + 3);
      else stop_at = len + 4;
      sum = id ^ len;
      send_byte(marker);
      frame_bytes++;
      for (int pos = 1; pos < stop_at; pos++) begin
         if (pos == 1) begin
            b = id;
         end else if (pos == 2) begin
            b = len;
         end else if (pos < len + 3) begin
            b   = byte_type'($urandom);
            sum = sum ^ b;
         end else if ($urandom_range(3) == 0) begin
            b = sum ^ byte_type'($urandom_range(1, 255));
         end else begin
            b = sum;
         end
         send_byte(b);
         frame_bytes++;
      end
   endtask

   initial begin
      byte_type directed_bytes[$];
      directed_bytes = '{
         8'h00, 8'hFF,                             // noise while hunting
         8'h55, 8'hFF, 8'h00, 8'hFF,               // zero length, good checksum
         8'h55, 8'h00, 8'h02, 8'h55, 8'hAA, 8'hFD, // marker inside payload
         8'h55, 8'h55, 8'h01, 8'h80, 8'h00,        // marker as id, bad checksum
         8'h13                                     // id and length held between frames
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_access(1'b0, MarkerAddr, '0);
      csr_access(1'b1, SpareAddr, 32'hFFFF_FFA5);
      csr_access(1'b0, MarkerAddr, '0);
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0:       marker = MarkerReset;
            1:       marker = 8'h00;
            2:       marker = 8'hFF;
            4:       marker = MarkerReset;
            default: marker = byte_type'($urandom);
         endcase
         // upper bits are noise that the register ignores
         csr_access(1'b1, MarkerAddr, {24'($urandom), marker});
         csr_access(1'b0, MarkerAddr, '0);
         case (p)
            1:       begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            3, 5:    begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         endcase
         // the sender keeps offering bytes while the receiver holds off
         if (p == 4) hold_cycles = HoldCycles;
         if (p == 2) send_random_frame(255);
         frame_bytes = 0;
         while (frame_bytes < ItemsPerPhase) send_random_frame(-1);
      end

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/xcfp_pkg.sv
rtl/core/xcfp_csr.sv
rtl/core/xcfp_parser.sv
rtl/core/xcfp_out_buf.sv
rtl/core/xor_checksum_frame_parser.sv
rtl/core/xcfp_checker.sv
tb/xcfp_checker.sv
tb/tb.sv
